>>> sv/msc_pkg.sv
// shared types and constants for the moon phase coverage shader
// no dependencies; imported by every module of the block
package msc_pkg;

    localparam int COORD_BITS_DEF    = 10;
    localparam int SUBPIXEL_BITS_DEF = 6;

    localparam int POS_W      = 16;
    localparam int RADIUS_W   = 12;
    localparam int PHASE_W    = 16;
    localparam int OPACITY_W  = 9;
    localparam int COLOR_W    = 24;
    localparam int CH_W       = 8;
    localparam int Q16_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [POS_W-1:0]     CX_RST      = 16'd0;
    localparam logic [POS_W-1:0]     CY_RST      = 16'd0;
    localparam logic [RADIUS_W-1:0]  RADIUS_RST  = 12'd704;
    localparam logic [PHASE_W-1:0]   PHASE_RST   = 16'd32768;
    localparam logic [OPACITY_W-1:0] OPACITY_RST = 9'd256;
    localparam logic [COLOR_W-1:0]   LIT_RST     = 24'd15527670;

    localparam logic [OPACITY_W-1:0] OPACITY_ONE = 9'd256;
    localparam logic [OPACITY_W-1:0] OPACITY_MIN = 9'd1;

    localparam logic [Q16_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [Q16_W-1:0] HALF_Q16 = 17'd32768;

    // quarter-wave cosine polynomial
    localparam logic [14:0] QUARTER = 15'd16384;
    localparam logic [6:0]  COS_C0  = 7'd60;
    localparam logic [10:0] COS_C1  = 11'd1367;
    localparam logic [14:0] COS_C2  = 15'd16624;
    localparam logic [16:0] COS_C3  = 17'd80852;

    localparam logic [12:0] EARTHSHINE = 13'd5898;
    // ceil(2^18 / 3), exact for dividends below 2^17
    localparam logic [16:0] RECIP3     = 17'd87382;
    localparam logic [CH_W-1:0] MIN_ALPHA = 8'd3;
    localparam logic [CH_W-1:0] MAX_ALPHA = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_RADIUS    = 3'd2,
        CFG_PHASE     = 3'd3,
        CFG_OPACITY   = 3'd4,
        CFG_LIT_COLOR = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic drop;
    } t_ctl;

endpackage

>>> sv/msc_cos.sv
// pipelined cosine of the phase register, Q16 magnitude and sign
// depends on msc_pkg; runs continuously on the live phase value
module msc_cos (
    input  logic                          i_clk,
    input  logic [msc_pkg::PHASE_W-1:0]   i_phase,
    output logic [msc_pkg::Q16_W-1:0]     o_mag,
    output logic                          o_neg
);
    import msc_pkg::*;

    logic [1:0]  quad;
    logic [13:0] frac;
    logic [14:0] q;
    logic [16:0] x;
    logic [33:0] xx;
    logic [22:0] p1;
    logic [27:0] p2;
    logic [31:0] p3;
    logic [33:0] p4;
    logic [17:0] t;

    logic [16:0] r_u0, r_u1, r_u2, r_u3;
    logic        r_neg0, r_neg1, r_neg2, r_neg3, r_neg;
    logic [10:0] r_r1;
    logic [14:0] r_r2;
    logic [16:0] r_r3;
    logic [16:0] r_mag;

    always_comb begin
        quad = i_phase[PHASE_W-1 -: 2];
        frac = i_phase[PHASE_W-3:0];
        q    = quad[0] ? (QUARTER - 15'(frac)) : 15'(frac);
        x    = {q, 2'b00};
        xx   = 34'(x) * 34'(x);
        p1   = 23'(r_u0) * 23'(COS_C0);
        p2   = 28'(r_r1) * 28'(r_u1);
        p3   = 32'(r_r2) * 32'(r_u2);
        p4   = 34'(r_r3) * 34'(r_u3);
        t    = p4[33:16];
    end

    always_ff @(posedge i_clk) begin
        r_u0   <= xx[32:16];
        r_neg0 <= (quad == 2'd1) || (quad == 2'd2);
        r_r1   <= COS_C1 - 11'(p1[22:16]);
        r_u1   <= r_u0;
        r_neg1 <= r_neg0;
        r_r2   <= COS_C2 - 15'(p2[27:16]);
        r_u2   <= r_u1;
        r_neg2 <= r_neg1;
        r_r3   <= COS_C3 - 17'(p3[31:16]);
        r_u3   <= r_u2;
        r_neg3 <= r_neg2;
        r_mag  <= (t >= 18'(ONE_Q16)) ? '0 : 17'(18'(ONE_Q16) - t);
        r_neg  <= r_neg3;
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg;

endmodule

>>> sv/msc_sqrt.sv
// two-lane pipelined integer square root, one root bit per stage
// depends on msc_pkg for the control struct; carries a payload alongside
module msc_sqrt #(
    parameter int SQ_N  = 23,
    parameter int PAY_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msc_pkg::t_ctl        i_ctl,
    input  logic [2*SQ_N-1:0]    i_rad_a,
    input  logic [2*SQ_N-1:0]    i_rad_b,
    input  logic [PAY_W-1:0]     i_pay,
    output msc_pkg::t_ctl        o_ctl,
    output logic [SQ_N-1:0]      o_root_a,
    output logic [SQ_N-1:0]      o_root_b,
    output logic [PAY_W-1:0]     o_pay
);
    import msc_pkg::*;

    localparam int RW = 2 * SQ_N;

    // returns {remainder, root} after one digit
    function automatic logic [2*SQ_N+1:0] sq_step(
        input logic [SQ_N+1:0] rem,
        input logic [SQ_N-1:0] root,
        input logic [1:0]      pair
    );
        logic [SQ_N+1:0] rem_t;
        logic [SQ_N+1:0] trial;
        rem_t = {rem[SQ_N-1:0], pair};
        trial = {root, 2'b01};
        if (rem_t >= trial) begin
            sq_step = {rem_t - trial, root[SQ_N-2:0], 1'b1};
        end else begin
            sq_step = {rem_t, root[SQ_N-2:0], 1'b0};
        end
    endfunction

    logic [RW-1:0]   r_rad_a  [0:SQ_N-1];
    logic [RW-1:0]   r_rad_b  [0:SQ_N-1];
    logic [SQ_N+1:0] r_rem_a  [0:SQ_N-1];
    logic [SQ_N+1:0] r_rem_b  [0:SQ_N-1];
    logic [SQ_N-1:0] r_root_a [0:SQ_N-1];
    logic [SQ_N-1:0] r_root_b [0:SQ_N-1];
    logic [PAY_W-1:0] r_pay   [0:SQ_N-1];
    t_ctl            r_ctl    [0:SQ_N-1];

    genvar g;
    generate
        for (g = 0; g < SQ_N; g++) begin : g_st
            logic [RW-1:0]     p_rad_a, p_rad_b;
            logic [SQ_N+1:0]   p_rem_a, p_rem_b;
            logic [SQ_N-1:0]   p_root_a, p_root_b;
            logic [PAY_W-1:0]  p_pay;
            t_ctl              p_ctl;
            logic [2*SQ_N+1:0] n_a, n_b;

            if (g == 0) begin : g_first
                assign p_rad_a  = i_rad_a;
                assign p_rad_b  = i_rad_b;
                assign p_rem_a  = '0;
                assign p_rem_b  = '0;
                assign p_root_a = '0;
                assign p_root_b = '0;
                assign p_pay    = i_pay;
                assign p_ctl    = i_ctl;
            end else begin : g_next
                assign p_rad_a  = r_rad_a[g-1];
                assign p_rad_b  = r_rad_b[g-1];
                assign p_rem_a  = r_rem_a[g-1];
                assign p_rem_b  = r_rem_b[g-1];
                assign p_root_a = r_root_a[g-1];
                assign p_root_b = r_root_b[g-1];
                assign p_pay    = r_pay[g-1];
                assign p_ctl    = r_ctl[g-1];
            end

            assign n_a = sq_step(p_rem_a, p_root_a, p_rad_a[RW-1 -: 2]);
            assign n_b = sq_step(p_rem_b, p_root_b, p_rad_b[RW-1 -: 2]);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[g] <= '0;
                end else begin
                    r_ctl[g] <= p_ctl;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rad_a[g]  <= {p_rad_a[RW-3:0], 2'b00};
                r_rad_b[g]  <= {p_rad_b[RW-3:0], 2'b00};
                r_rem_a[g]  <= n_a[2*SQ_N+1:SQ_N];
                r_rem_b[g]  <= n_b[2*SQ_N+1:SQ_N];
                r_root_a[g] <= n_a[SQ_N-1:0];
                r_root_b[g] <= n_b[SQ_N-1:0];
                r_pay[g]    <= p_pay;
            end
        end
    endgenerate

    assign o_ctl    = r_ctl[SQ_N-1];
    assign o_root_a = r_root_a[SQ_N-1];
    assign o_root_b = r_root_b[SQ_N-1];
    assign o_pay    = r_pay[SQ_N-1];

endmodule

>>> sv/msc_shade.sv
// back end: limb coverage, terminator, earthshine and alpha, output register
// depends on msc_pkg; fed by the square root pipeline and the cosine unit
module msc_shade #(
    parameter int COORD_BITS    = 10,
    parameter int SUBPIXEL_BITS = 6,
    parameter int SQ_N          = 23,
    parameter int DX_W          = 17
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  msc_pkg::t_ctl                   i_ctl,
    input  logic [COORD_BITS-1:0]           i_x,
    input  logic [COORD_BITS-1:0]           i_y,
    input  logic signed [DX_W-1:0]          i_dx,
    input  logic [SQ_N-1:0]                 i_dist,
    input  logic [SQ_N-1:0]                 i_h,
    input  logic [msc_pkg::RADIUS_W-1:0]    i_radius,
    input  logic [msc_pkg::Q16_W-1:0]       i_ct_mag,
    input  logic                            i_ct_neg,
    input  logic                            i_waxing,
    input  logic [msc_pkg::OPACITY_W-1:0]   i_opacity,
    input  logic [msc_pkg::COLOR_W-1:0]     i_lit,
    output logic                            o_strobe,
    output logic [COORD_BITS-1:0]           o_out_x,
    output logic [COORD_BITS-1:0]           o_out_y,
    output logic                            o_write_pixel,
    output logic [msc_pkg::CH_W-1:0]        o_coverage_alpha,
    output logic [msc_pkg::CH_W-1:0]        o_out_red,
    output logic [msc_pkg::CH_W-1:0]        o_out_green,
    output logic [msc_pkg::CH_W-1:0]        o_out_blue
);
    import msc_pkg::*;

    localparam int UP     = 16 - SUBPIXEL_BITS;
    localparam int R16_W  = RADIUS_W + UP;
    localparam int DV_W   = (R16_W > SQ_N ? R16_W : SQ_N) + 2;
    localparam int DX16_W = DX_W + UP;
    localparam int MAG_W  = SQ_N + 1;
    localparam int SIDE_W = (DX16_W > MAG_W + 1 ? DX16_W : MAG_W + 1) + 1;

    // stage d: limb distance and terminator offset
    logic signed [DV_W-1:0]  dv;
    logic [Q16_W+SQ_N-1:0]   mag_prod;
    t_ctl                    r_d_ctl;
    logic [COORD_BITS-1:0]   r_d_x, r_d_y;
    logic [Q16_W-1:0]        r_d_disc;
    logic [MAG_W-1:0]        r_d_mag;
    logic signed [DX16_W-1:0] r_d_dx16;

    always_comb begin
        dv = $signed(DV_W'({i_radius, {UP{1'b0}}})) + $signed(DV_W'(HALF_Q16))
           - $signed(DV_W'(i_dist));
        mag_prod = (Q16_W+SQ_N)'(i_ct_mag) * (Q16_W+SQ_N)'(i_h);
    end

    // stage e: signed side of the terminator
    logic signed [SIDE_W-1:0] xt;
    logic signed [SIDE_W-1:0] n_side;
    t_ctl                     r_e_ctl;
    logic [COORD_BITS-1:0]    r_e_x, r_e_y;
    logic [Q16_W-1:0]         r_e_disc;
    logic signed [SIDE_W-1:0] r_e_side;

    always_comb begin
        xt = i_ct_neg ? -$signed(SIDE_W'(r_d_mag)) : $signed(SIDE_W'(r_d_mag));
        if (i_waxing) begin
            n_side = SIDE_W'(r_d_dx16) - xt;
        end else begin
            n_side = -xt - SIDE_W'(r_d_dx16);
        end
    end

    // stage f: one half plus 2*side/3 by reciprocal, then clamp into 0..1
    logic [SIDE_W-1:0] v;
    logic              sat;
    logic [16:0]       v2;
    logic [33:0]       q_prod;
    logic [15:0]       q;
    logic [17:0]       q_sum;
    logic [Q16_W-1:0]  n_term;
    t_ctl              r_f_ctl;
    logic [COORD_BITS-1:0] r_f_x, r_f_y;
    logic [Q16_W-1:0]  r_f_disc, r_f_term;

    always_comb begin
        v      = r_e_side[SIDE_W-1] ? SIDE_W'(-r_e_side) : SIDE_W'(r_e_side);
        sat    = |v[SIDE_W-1:16];
        v2     = {v[15:0], 1'b0};
        q_prod = 34'(v2) * 34'(RECIP3);
        q      = q_prod[33:18];
        q_sum  = 18'(HALF_Q16) + 18'(q);
        if (sat) begin
            n_term = r_e_side[SIDE_W-1] ? '0 : ONE_Q16;
        end else if (r_e_side[SIDE_W-1]) begin
            n_term = (17'(q) > HALF_Q16) ? '0 : HALF_Q16 - 17'(q);
        end else begin
            n_term = (q_sum > 18'(ONE_Q16)) ? ONE_Q16 : q_sum[16:0];
        end
    end

    // stage g: earthshine mix and opacity times limb
    logic [29:0]       es_prod;
    t_ctl              r_g_ctl;
    logic [COORD_BITS-1:0] r_g_x, r_g_y;
    logic [Q16_W-1:0]  r_g_k;
    logic [24:0]       r_g_od;

    assign es_prod = 30'(ONE_Q16 - r_f_term) * 30'(EARTHSHINE);

    // stage h: full product
    t_ctl              r_h_ctl;
    logic [COORD_BITS-1:0] r_h_x, r_h_y;
    logic [41:0]       r_h_p;

    // output stage: times 255, scale down, threshold
    logic [49:0]       ap;
    logic [CH_W-1:0]   alpha;
    logic              wr;

    always_comb begin
        ap    = (50'(r_h_p) << 8) - 50'(r_h_p);
        alpha = (|ap[49:48]) ? MAX_ALPHA : ap[47:40];
        wr    = r_h_ctl.valid && !r_h_ctl.drop && (alpha >= MIN_ALPHA);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl  <= '0;
            r_e_ctl  <= '0;
            r_f_ctl  <= '0;
            r_g_ctl  <= '0;
            r_h_ctl  <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_d_ctl.valid <= i_ctl.valid;
            r_d_ctl.drop  <= i_ctl.drop || (dv <= 0);
            r_e_ctl  <= r_d_ctl;
            r_f_ctl  <= r_e_ctl;
            r_g_ctl  <= r_f_ctl;
            r_h_ctl  <= r_g_ctl;
            o_strobe <= r_h_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_x    <= i_x;
        r_d_y    <= i_y;
        r_d_disc <= (dv > $signed(DV_W'(ONE_Q16))) ? ONE_Q16 : dv[Q16_W-1:0];
        r_d_mag  <= mag_prod[Q16_W+SQ_N-1:16];
        r_d_dx16 <= DX16_W'(i_dx) <<< UP;

        r_e_x    <= r_d_x;
        r_e_y    <= r_d_y;
        r_e_disc <= r_d_disc;
        r_e_side <= n_side;

        r_f_x    <= r_e_x;
        r_f_y    <= r_e_y;
        r_f_disc <= r_e_disc;
        r_f_term <= n_term;

        r_g_x    <= r_f_x;
        r_g_y    <= r_f_y;
        r_g_k    <= r_f_term + 17'(es_prod[29:16]);
        r_g_od   <= 25'(i_opacity) * 25'(r_f_disc);

        r_h_x    <= r_g_x;
        r_h_y    <= r_g_y;
        r_h_p    <= 42'(r_g_od) * 42'(r_g_k);

        o_out_x          <= r_h_x;
        o_out_y          <= r_h_y;
        o_write_pixel    <= wr;
        o_coverage_alpha <= wr ? alpha : '0;
        o_out_red        <= wr ? i_lit[23:16] : '0;
        o_out_green      <= wr ? i_lit[15:8] : '0;
        o_out_blue       <= wr ? i_lit[7:0] : '0;
    end

endmodule

>>> sv/moon_phase_coverage_shader.sv
// moon disc coverage shader: one pixel request per clock while not busy, one result per request
// result path: stages a to c, the square root pipeline of 29 - SUBPIXEL_BITS stages,
// then stages d to h and the output register of the back end
// throughput: one pixel every cycle; busy is high only during and just after reset
// reset: synchronous active low, clears valid bits and loads register defaults
// results come with o_strobe for one cycle and cannot be stalled
module moon_phase_coverage_shader #(
    parameter int COORD_BITS    = msc_pkg::COORD_BITS_DEF,
    parameter int SUBPIXEL_BITS = msc_pkg::SUBPIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             i_pixel_x,
    input  logic [COORD_BITS-1:0]             i_pixel_y,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_strobe,
    output logic [COORD_BITS-1:0]             o_out_x,
    output logic [COORD_BITS-1:0]             o_out_y,
    output logic                              o_write_pixel,
    output logic [msc_pkg::CH_W-1:0]          o_coverage_alpha,
    output logic [msc_pkg::CH_W-1:0]          o_out_red,
    output logic [msc_pkg::CH_W-1:0]          o_out_green,
    output logic [msc_pkg::CH_W-1:0]          o_out_blue
);
    import msc_pkg::*;

    localparam int PIX_W = COORD_BITS + SUBPIXEL_BITS;
    localparam int DX_W  = (PIX_W > POS_W ? PIX_W : POS_W) + 1;
    localparam int AW    = DX_W - 1;
    localparam int SW    = 2 * AW + 1;
    localparam int RS_W  = 2 * RADIUS_W + 1;
    localparam int SHIFT = 32 - 2 * SUBPIXEL_BITS;
    localparam int SQ_N  = (RS_W + SHIFT + 1) / 2;
    localparam int SQ_W  = 2 * SQ_N;
    localparam int PAY_W = 2 * COORD_BITS + DX_W;
    localparam int LAT   = SQ_N + 9;

    // configuration registers
    logic [POS_W-1:0]     r_cx, r_cy;
    logic [RADIUS_W-1:0]  r_radius;
    logic [PHASE_W-1:0]   r_phase;
    logic [OPACITY_W-1:0] r_opacity;
    logic [COLOR_W-1:0]   r_lit;
    logic [2*RADIUS_W-1:0] r_r2;
    logic                 r_busy;

    logic [OPACITY_W-1:0] op_sat;
    logic                 disabled;
    logic                 accept;

    assign o_cfg_ready = 1'b1;
    assign busy        = r_busy;
    assign accept      = start && !r_busy;
    assign op_sat      = (r_opacity > OPACITY_ONE) ? OPACITY_ONE : r_opacity;
    assign disabled    = (op_sat <= OPACITY_MIN) || (r_radius == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= CX_RST;
            r_cy      <= CY_RST;
            r_radius  <= RADIUS_RST;
            r_phase   <= PHASE_RST;
            r_opacity <= OPACITY_RST;
            r_lit     <= LIT_RST;
            r_busy    <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CENTER_X:  r_cx      <= i_cfg_data[POS_W-1:0];
                    CFG_CENTER_Y:  r_cy      <= i_cfg_data[POS_W-1:0];
                    CFG_RADIUS:    r_radius  <= i_cfg_data[RADIUS_W-1:0];
                    CFG_PHASE:     r_phase   <= i_cfg_data[PHASE_W-1:0];
                    CFG_OPACITY:   r_opacity <= i_cfg_data[OPACITY_W-1:0];
                    CFG_LIT_COLOR: r_lit     <= i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= (2*RADIUS_W)'(r_radius) * (2*RADIUS_W)'(r_radius);
    end

    // stage a: offsets of the pixel center from the disc center
    logic [PIX_W-1:0]        px_c, py_c;
    t_ctl                    r_a_ctl;
    logic [COORD_BITS-1:0]   r_a_x, r_a_y;
    logic signed [DX_W-1:0]  r_a_dx, r_a_dy;

    assign px_c = {i_pixel_x, 1'b1, {(SUBPIXEL_BITS-1){1'b0}}};
    assign py_c = {i_pixel_y, 1'b1, {(SUBPIXEL_BITS-1){1'b0}}};

    // stage b: squares
    logic [AW-1:0]           adx, ady;
    t_ctl                    r_b_ctl;
    logic [COORD_BITS-1:0]   r_b_x, r_b_y;
    logic signed [DX_W-1:0]  r_b_dx;
    logic [2*AW-1:0]         r_b_dx2, r_b_dy2;

    assign adx = r_a_dx[DX_W-1] ? AW'(-r_a_dx) : AW'(r_a_dx);
    assign ady = r_a_dy[DX_W-1] ? AW'(-r_a_dy) : AW'(r_a_dy);

    // stage c: far test and square root radicands
    logic [SW-1:0]           s;
    logic [SW+2:0]           s5, r8;
    logic                    far;
    t_ctl                    r_c_ctl;
    logic [SQ_W-1:0]         r_c_rad_d, r_c_rad_h;
    logic [PAY_W-1:0]        r_c_pay;

    always_comb begin
        s   = SW'(r_b_dx2) + SW'(r_b_dy2);
        s5  = (SW+3)'(s) + ((SW+3)'(s) << 2);
        r8  = (SW+3)'(r_r2) << 3;
        far = s5 > r8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
            r_b_ctl <= '0;
            r_c_ctl <= '0;
        end else begin
            r_a_ctl.valid <= accept;
            r_a_ctl.drop  <= disabled;
            r_b_ctl       <= r_a_ctl;
            r_c_ctl.valid <= r_b_ctl.valid;
            r_c_ctl.drop  <= r_b_ctl.drop || far;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x   <= i_pixel_x;
        r_a_y   <= i_pixel_y;
        r_a_dx  <= $signed(DX_W'(px_c)) - $signed(DX_W'(r_cx));
        r_a_dy  <= $signed(DX_W'(py_c)) - $signed(DX_W'(r_cy));

        r_b_x   <= r_a_x;
        r_b_y   <= r_a_y;
        r_b_dx  <= r_a_dx;
        r_b_dx2 <= (2*AW)'(adx) * (2*AW)'(adx);
        r_b_dy2 <= (2*AW)'(ady) * (2*AW)'(ady);

        // far pixels get a masked radicand; their root is never used
        r_c_rad_d <= SQ_W'({s[RS_W-1:0], {SHIFT{1'b0}}});
        if (r_b_dy2 >= (2*AW)'(r_r2)) begin
            r_c_rad_h <= '0;
        end else begin
            r_c_rad_h <= SQ_W'({r_r2 - r_b_dy2[2*RADIUS_W-1:0], {SHIFT{1'b0}}});
        end
        r_c_pay <= {r_b_x, r_b_y, r_b_dx};
    end

    t_ctl             sq_ctl;
    logic [SQ_N-1:0]  sq_dist, sq_h;
    logic [PAY_W-1:0] sq_pay;

    msc_sqrt #(
        .SQ_N  (SQ_N),
        .PAY_W (PAY_W)
    ) u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_c_ctl),
        .i_rad_a  (r_c_rad_d),
        .i_rad_b  (r_c_rad_h),
        .i_pay    (r_c_pay),
        .o_ctl    (sq_ctl),
        .o_root_a (sq_dist),
        .o_root_b (sq_h),
        .o_pay    (sq_pay)
    );

    logic [Q16_W-1:0] ct_mag;
    logic             ct_neg;

    msc_cos u_cos (
        .i_clk   (i_clk),
        .i_phase (r_phase),
        .o_mag   (ct_mag),
        .o_neg   (ct_neg)
    );

    msc_shade #(
        .COORD_BITS    (COORD_BITS),
        .SUBPIXEL_BITS (SUBPIXEL_BITS),
        .SQ_N          (SQ_N),
        .DX_W          (DX_W)
    ) u_shade (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (sq_ctl),
        .i_x              (sq_pay[PAY_W-1 -: COORD_BITS]),
        .i_y              (sq_pay[DX_W +: COORD_BITS]),
        .i_dx             ($signed(sq_pay[DX_W-1:0])),
        .i_dist           (sq_dist),
        .i_h              (sq_h),
        .i_radius         (r_radius),
        .i_ct_mag         (ct_mag),
        .i_ct_neg         (ct_neg),
        .i_waxing         (!r_phase[PHASE_W-1]),
        .i_opacity        (op_sat),
        .i_lit            (r_lit),
        .o_strobe         (o_strobe),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_write_pixel    (o_write_pixel),
        .o_coverage_alpha (o_coverage_alpha),
        .o_out_red        (o_out_red),
        .o_out_green      (o_out_green),
        .o_out_blue       (o_out_blue)
    );

`ifndef NO_ASSERTIONS
    // every result traces back to a request a fixed number of cycles earlier
    a_strobe_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LAT))
        else $error("result strobe without matching request");

    a_write_has_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_pixel |-> (o_strobe && (o_coverage_alpha >= MIN_ALPHA)))
        else $error("pixel write with faint alpha or no strobe");

    a_skip_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_write_pixel) |->
            (o_coverage_alpha == '0 && o_out_red == '0 && o_out_green == '0
             && o_out_blue == '0))
        else $error("skipped pixel carries color");
`endif

endmodule
